@@ hw/rtl/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor package
// Command and status codes, field widths and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbe_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;
   localparam int LEN_W  = 7;
   localparam int CNT_W  = 7;
   localparam int STAT_W = 2;
   localparam int CMD_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_SET    = 3'd2,
      CMD_GET    = 3'd3,
      CMD_POP    = 3'd4,
      CMD_REMOVE = 3'd5,
      CMD_CLEAR  = 3'd6,
      CMD_RUN    = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Source of the byte reported in a result.
   typedef enum logic [1:0] {
      BSEL_ZERO  = 2'd0,
      BSEL_RDATA = 2'd1,
      BSEL_SAVE  = 2'd2
   } bsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture the request fields
      logic       append_wr;  // write the byte at the fill count, count up
      logic       set_wr;     // overwrite the byte at the position
      logic       clear;      // empty the buffer
      logic       rd_pos;     // read the entry at the position
      logic       pop;        // count down and read the last entry
      logic       ins_init;   // start the upward shift at the fill count
      logic       shift_up;   // one step of the upward shift
      logic       ins_fin;    // write the new byte at the position, count up
      logic       rem_init;   // start the downward shift at the position
      logic       save;       // hold the byte being removed
      logic       shift_dn;   // one step of the downward shift
      logic       rem_fin;    // count down after a removal
      logic       run_init;   // load the run start and length
      logic       run_step;   // issue the next run read
      logic       emit;       // load the result registers
      status_type status;
      bsel_type   bsel;
      logic       last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    pos_oob;     // position at or beyond the fill count
      logic    full;
      logic    empty;
      logic    run_bad;     // run leaves the filled region
      logic    len_zero;
      logic    up_done;     // upward shift finished, write port free
      logic    dn_done;     // downward shift finished, write port free
      logic    run_rem_zero;
      logic    run_pend;    // read data for a run beat is present
      logic    run_last;    // that beat is the final one
   } dp_stat_type;

endpackage

@@ hw/rtl/char_buffer_editor_unit.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor
// Fixed-capacity byte buffer with append, insert, set, get, pop, remove,
// clear and run-read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; the block then
// works on that one command until it is finished. Every command produces at
// least one result beat on the rsp_ ports, marked by rsp_strobe for a single
// cycle, and the receiver must take it there and then because nothing here
// waits for it. Append, set, clear and any command that ends in an error
// finish in the decode state; get and pop add a read state, since the byte
// store has a registered read. Insert and remove move the tail of the
// buffer one entry per cycle through the single read and single write port
// of the store; the one exception is removing the final entry, which moves
// nothing. A run read streams one byte per cycle, with its final beat
// flagged by rsp_last. The store holds no meaningful contents after reset
// and needs no clearing pass: only entries below the fill count are ever
// read.
// ----------------------------------------------------------------------------
module char_buffer_editor_unit
   import cbe_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [POS_W-1:0]  req_position,
   input  logic [LEN_W-1:0]  req_run_length,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CNT_W-1:0]  rsp_fill_count,
   output logic              rsp_last
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // The controller owns the sequencing; the datapath owns all storage.
   cbe_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .dp_stat (dp_stat),
      .dp_cmd  (dp_cmd)
   );

   cbe_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_byte_in    (req_byte_in),
      .req_position   (req_position),
      .req_run_length (req_run_length),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .rsp_last       (rsp_last)
   );

   // The reported fill count can never exceed the capacity.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_fill_count <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // An error beat carries no byte and always ends its command.
   a_error_beat : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_byte_out == '0 && rsp_last))
      else $error("error beat with byte or without last");

   // The cycle after a command is taken is spent decoding: busy, no beat.
   a_accept_decode : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("beat or idle straight after acceptance");

endmodule

@@ hw/rtl/cbe_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module cbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cbe_dp.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor datapath
// Request registers, fill count, shift and run index counters, byte store
// and the result registers.
// ----------------------------------------------------------------------------
module cbe_dp
   import cbe_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [POS_W-1:0]  req_position,
   input  logic [LEN_W-1:0]  req_run_length,
   input  dp_cmd_type        dp_cmd,
   output dp_stat_type       dp_stat,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic [STAT_W-1:0] rsp_status,
   output logic [CNT_W-1:0]  rsp_fill_count,
   output logic              rsp_last
);

   localparam int ADDR_W = $clog2(CAPACITY);

   // Request fields held for the whole operation.
   cmd_type           cmd_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [LEN_W-1:0]  len_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic              wpend_ff, wpend_in;
   logic              rpend_ff, rpend_in;
   logic              rlast_ff, rlast_in;
   logic [BYTE_W-1:0] save_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;

   logic [CNT_W-1:0]  pos_ext;
   logic [CNT_W:0]    run_end;
   logic [CNT_W-1:0]  idx_plus;
   logic [CNT_W-1:0]  idx_minus;
   logic [CNT_W-1:0]  count_minus;
   logic              up_more, dn_more;

   assign pos_ext     = CNT_W'(pos_ff);
   assign run_end     = (CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(len_ff);
   assign idx_plus    = idx_ff + CNT_W'(1);
   assign idx_minus   = idx_ff - CNT_W'(1);
   assign count_minus = count_ff - CNT_W'(1);
   assign up_more     = idx_ff > pos_ext;
   assign dn_more     = idx_plus < count_ff;

   always_comb begin
      dp_stat.cmd          = cmd_ff;
      dp_stat.pos_oob      = pos_ext >= count_ff;
      dp_stat.full         = count_ff >= CNT_W'(CAPACITY);
      dp_stat.empty        = count_ff == '0;
      dp_stat.run_bad      = (pos_ext >= count_ff) || (run_end > {1'b0, count_ff});
      dp_stat.len_zero     = len_ff == '0;
      dp_stat.up_done      = !up_more && !wpend_ff;
      dp_stat.dn_done      = !dn_more && !wpend_ff;
      dp_stat.run_rem_zero = rem_ff == '0;
      dp_stat.run_pend     = rpend_ff;
      dp_stat.run_last     = rlast_ff;
   end

   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      waddr_in    = waddr_ff;
      wpend_in    = wpend_ff;
      rpend_in    = rpend_ff;
      rlast_in    = rlast_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff[ADDR_W-1:0];
      ram_wr_data = byte_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff[ADDR_W-1:0];

      // A pending shift write moves the entry read in the previous cycle.
      if (wpend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = waddr_ff;
         ram_wr_data = ram_rd_data;
      end

      if (dp_cmd.append_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = count_ff[ADDR_W-1:0];
         count_in    = count_ff + CNT_W'(1);
      end
      if (dp_cmd.set_wr) begin
         ram_wr_en = 1'b1;
      end
      if (dp_cmd.clear) begin
         count_in = '0;
      end
      if (dp_cmd.rd_pos) begin
         ram_rd_en = 1'b1;
      end
      if (dp_cmd.pop) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = count_minus[ADDR_W-1:0];
         count_in    = count_minus;
      end
      if (dp_cmd.ins_init) begin
         idx_in   = count_ff;
         wpend_in = 1'b0;
      end
      if (dp_cmd.shift_up) begin
         if (up_more) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_minus[ADDR_W-1:0];
            waddr_in    = idx_ff[ADDR_W-1:0];
            idx_in      = idx_minus;
            wpend_in    = 1'b1;
         end else begin
            wpend_in = 1'b0;
         end
      end
      if (dp_cmd.ins_fin) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pos_ff[ADDR_W-1:0];
         ram_wr_data = byte_ff;
         count_in    = count_ff + CNT_W'(1);
      end
      if (dp_cmd.rem_init) begin
         idx_in   = pos_ext;
         wpend_in = 1'b0;
      end
      if (dp_cmd.shift_dn) begin
         if (dn_more) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_plus[ADDR_W-1:0];
            waddr_in    = idx_ff[ADDR_W-1:0];
            idx_in      = idx_plus;
            wpend_in    = 1'b1;
         end else begin
            wpend_in = 1'b0;
         end
      end
      if (dp_cmd.rem_fin) begin
         count_in = count_minus;
      end
      if (dp_cmd.run_init) begin
         idx_in   = pos_ext;
         rem_in   = len_ff;
         rpend_in = 1'b0;
      end
      if (dp_cmd.run_step) begin
         if (rem_ff != '0) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff[ADDR_W-1:0];
            idx_in      = idx_plus;
            rem_in      = rem_ff - LEN_W'(1);
            rpend_in    = 1'b1;
            rlast_in    = rem_ff == LEN_W'(1);
         end else begin
            rpend_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_strobe_in = dp_cmd.emit;
      rsp_status_in = dp_cmd.status;
      rsp_last_in   = dp_cmd.last;
      rsp_fill_in   = count_in;
      case (dp_cmd.bsel)
         BSEL_RDATA: rsp_byte_in = ram_rd_data;
         BSEL_SAVE:  rsp_byte_in = save_ff;
         default:    rsp_byte_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         wpend_ff      <= 1'b0;
         rpend_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         wpend_ff      <= wpend_in;
         rpend_ff      <= rpend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff  <= cmd_type'(req_cmd);
         byte_ff <= req_byte_in;
         pos_ff  <= req_position;
         len_ff  <= req_run_length;
      end
      if (dp_cmd.save) begin
         save_ff <= ram_rd_data;
      end
      idx_ff   <= idx_in;
      rem_ff   <= rem_in;
      waddr_ff <= waddr_in;
      rlast_ff <= rlast_in;
      if (dp_cmd.emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   cbe_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_byte_out   = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ hw/rtl/cbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor controller
// Decodes the captured command and sequences checks, shifts and run reads.
// ----------------------------------------------------------------------------
module cbe_ctrl
   import cbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DECODE   = 7'b0000010,
      S_READ     = 7'b0000100,
      S_SHIFT_UP = 7'b0001000,
      S_REM_SAVE = 7'b0010000,
      S_SHIFT_DN = 7'b0100000,
      S_RUN      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = state_ff != S_IDLE;

   // Loads a one-beat result of the given status.
   function automatic dp_cmd_type with_emit(dp_cmd_type c, status_type st, bsel_type bs);
      dp_cmd_type r;
      r        = c;
      r.emit   = 1'b1;
      r.status = st;
      r.bsel   = bs;
      r.last   = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (dp_stat.cmd)
               CMD_APPEND: begin
                  if (dp_stat.full) begin
                     dp_cmd = with_emit(dp_cmd, ST_FULL, BSEL_ZERO);
                  end else begin
                     dp_cmd.append_wr = 1'b1;
                     dp_cmd           = with_emit(dp_cmd, ST_OK, BSEL_ZERO);
                  end
               end
               CMD_INSERT: begin
                  if (dp_stat.pos_oob) begin
                     dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
                  end else if (dp_stat.full) begin
                     dp_cmd = with_emit(dp_cmd, ST_FULL, BSEL_ZERO);
                  end else begin
                     dp_cmd.ins_init = 1'b1;
                     state_in        = S_SHIFT_UP;
                  end
               end
               CMD_SET: begin
                  if (dp_stat.pos_oob) begin
                     dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
                  end else begin
                     dp_cmd.set_wr = 1'b1;
                     dp_cmd        = with_emit(dp_cmd, ST_OK, BSEL_ZERO);
                  end
               end
               CMD_GET: begin
                  if (dp_stat.pos_oob) begin
                     dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
                  end else begin
                     dp_cmd.rd_pos = 1'b1;
                     state_in      = S_READ;
                  end
               end
               CMD_POP: begin
                  if (dp_stat.empty) begin
                     dp_cmd = with_emit(dp_cmd, ST_EMPTY, BSEL_ZERO);
                  end else begin
                     dp_cmd.pop = 1'b1;
                     state_in   = S_READ;
                  end
               end
               CMD_REMOVE: begin
                  if (dp_stat.pos_oob) begin
                     dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
                  end else begin
                     dp_cmd.rd_pos   = 1'b1;
                     dp_cmd.rem_init = 1'b1;
                     state_in        = S_REM_SAVE;
                  end
               end
               CMD_CLEAR: begin
                  dp_cmd.clear = 1'b1;
                  dp_cmd       = with_emit(dp_cmd, ST_OK, BSEL_ZERO);
               end
               CMD_RUN: begin
                  if (dp_stat.run_bad) begin
                     dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
                  end else if (dp_stat.len_zero) begin
                     dp_cmd = with_emit(dp_cmd, ST_OK, BSEL_ZERO);
                  end else begin
                     dp_cmd.run_init = 1'b1;
                     state_in        = S_RUN;
                  end
               end
               default: begin
                  dp_cmd = with_emit(dp_cmd, ST_BOUNDS, BSEL_ZERO);
               end
            endcase
         end
         S_READ: begin
            dp_cmd   = with_emit(dp_cmd, ST_OK, BSEL_RDATA);
            state_in = S_IDLE;
         end
         S_SHIFT_UP: begin
            if (dp_stat.up_done) begin
               dp_cmd.ins_fin = 1'b1;
               dp_cmd         = with_emit(dp_cmd, ST_OK, BSEL_ZERO);
               state_in       = S_IDLE;
            end else begin
               dp_cmd.shift_up = 1'b1;
            end
         end
         S_REM_SAVE: begin
            dp_cmd.save = 1'b1;
            state_in    = S_SHIFT_DN;
         end
         S_SHIFT_DN: begin
            if (dp_stat.dn_done) begin
               dp_cmd.rem_fin = 1'b1;
               dp_cmd         = with_emit(dp_cmd, ST_OK, BSEL_SAVE);
               state_in       = S_IDLE;
            end else begin
               dp_cmd.shift_dn = 1'b1;
            end
         end
         S_RUN: begin
            dp_cmd.run_step = 1'b1;
            if (dp_stat.run_pend) begin
               dp_cmd.emit   = 1'b1;
               dp_cmd.status = ST_OK;
               dp_cmd.bsel   = BSEL_RDATA;
               dp_cmd.last   = dp_stat.run_last;
               if (dp_stat.run_rem_zero) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ dv/edit_result_checker.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor result checker
// Watches the command and result channels, keeps its own copy of the buffer
// and fill count, and compares every result beat with the expected one.
// ----------------------------------------------------------------------------
module edit_result_checker
   import cbe_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [BYTE_W-1:0] req_byte_in,
   input  logic [POS_W-1:0]  req_position,
   input  logic [LEN_W-1:0]  req_run_length,
   input  logic              rsp_strobe,
   input  logic [BYTE_W-1:0] rsp_byte_out,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [CNT_W-1:0]  rsp_fill_count,
   input  logic              rsp_last,
   input  logic              run_done,
   output int                error_count,
   output int                outstanding
);

   typedef struct {
      logic [BYTE_W-1:0] byte_out;
      status_type        status;
      logic [CNT_W-1:0]  fill_count;
      logic              last;
   } edit_result_type;

   logic [BYTE_W-1:0] shadow_bytes [CAPACITY];
   int                shadow_fill;
   edit_result_type   expected_results [$];
   bit                drain_checked;

   initial begin
      error_count   = 0;
      outstanding   = 0;
      shadow_fill   = 0;
      drain_checked = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] edit checker: %s", $time, msg);
   endtask

   task automatic push_result(input logic [BYTE_W-1:0] b, input status_type st,
                              input logic last);
      edit_result_type r;
      r.byte_out   = b;
      r.status     = st;
      r.fill_count = CNT_W'(shadow_fill);
      r.last       = last;
      expected_results.push_back(r);
   endtask

   // Applies one accepted command to the shadow buffer and queues the beats
   // that it should produce.
   task automatic apply_edit(input cmd_type op, input logic [BYTE_W-1:0] b,
                             input int pos, input int len);
      int                i;
      logic [BYTE_W-1:0] taken;
      case (op)
         CMD_APPEND: begin
            if (shadow_fill >= CAPACITY) begin
               push_result('0, ST_FULL, 1'b1);
            end else begin
               shadow_bytes[shadow_fill] = b;
               shadow_fill++;
               push_result('0, ST_OK, 1'b1);
            end
         end
         CMD_INSERT: begin
            // The bounds test comes before the full test.
            if (pos >= shadow_fill) begin
               push_result('0, ST_BOUNDS, 1'b1);
            end else if (shadow_fill >= CAPACITY) begin
               push_result('0, ST_FULL, 1'b1);
            end else begin
               for (i = shadow_fill; i > pos; i--) shadow_bytes[i] = shadow_bytes[i-1];
               shadow_bytes[pos] = b;
               shadow_fill++;
               push_result('0, ST_OK, 1'b1);
            end
         end
         CMD_SET: begin
            if (pos >= shadow_fill) begin
               push_result('0, ST_BOUNDS, 1'b1);
            end else begin
               shadow_bytes[pos] = b;
               push_result('0, ST_OK, 1'b1);
            end
         end
         CMD_GET: begin
            if (pos >= shadow_fill) push_result('0, ST_BOUNDS, 1'b1);
            else push_result(shadow_bytes[pos], ST_OK, 1'b1);
         end
         CMD_POP: begin
            if (shadow_fill == 0) begin
               push_result('0, ST_EMPTY, 1'b1);
            end else begin
               shadow_fill--;
               push_result(shadow_bytes[shadow_fill], ST_OK, 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (pos >= shadow_fill) begin
               push_result('0, ST_BOUNDS, 1'b1);
            end else begin
               taken = shadow_bytes[pos];
               for (i = pos; i + 1 < shadow_fill; i++) shadow_bytes[i] = shadow_bytes[i+1];
               shadow_fill--;
               push_result(taken, ST_OK, 1'b1);
            end
         end
         CMD_CLEAR: begin
            shadow_fill = 0;
            push_result('0, ST_OK, 1'b1);
         end
         default: begin
            if (pos >= shadow_fill || pos + len > shadow_fill) begin
               push_result('0, ST_BOUNDS, 1'b1);
            end else if (len == 0) begin
               push_result('0, ST_OK, 1'b1);
            end else begin
               for (i = 0; i < len; i++) begin
                  push_result(shadow_bytes[pos+i], ST_OK, (i + 1 == len));
               end
            end
         end
      endcase
   endtask

   task automatic compare_beat();
      edit_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat byte=%0h status=%0d fill=%0d",
                                   rsp_byte_out, rsp_status, rsp_fill_count));
         return;
      end
      want = expected_results.pop_front();
      if (rsp_byte_out !== want.byte_out)
         report_mismatch($sformatf("byte_out %0h, expected %0h", rsp_byte_out, want.byte_out));
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, expected %s", rsp_status, want.status.name()));
      if (rsp_fill_count !== want.fill_count)
         report_mismatch($sformatf("fill_count %0d, expected %0d",
                                   rsp_fill_count, want.fill_count));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
   endtask

   // Results are compared before a new command is predicted, so a final beat
   // that coincides with the next acceptance is matched against the old one.
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         shadow_fill = 0;
      end else begin
         if (rsp_strobe === 1'b1) compare_beat();
         else if (rsp_strobe !== 1'b0) report_mismatch("result strobe is unknown");
         if (start && busy === 1'b0) begin
            apply_edit(cmd_type'(req_cmd), req_byte_in, int'(req_position),
                       int'(req_run_length));
         end
         if (run_done && !drain_checked) begin
            drain_checked = 1'b1;
            if (expected_results.size() != 0)
               report_mismatch($sformatf("%0d expected result beats never arrived",
                                         expected_results.size()));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Character buffer editor testbench
// Drives directed and random edit commands into the buffer editor under
// changing amounts of sender idling, while a checker alongside predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import cbe_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_BEATS = 84;

   logic              clock;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic [CMD_W-1:0]  req_cmd        = '0;
   logic [BYTE_W-1:0] req_byte_in    = '0;
   logic [POS_W-1:0]  req_position   = '0;
   logic [LEN_W-1:0]  req_run_length = '0;
   logic              run_done       = 1'b0;

   logic              busy;
   logic              rsp_strobe;
   logic [BYTE_W-1:0] rsp_byte_out;
   logic [STAT_W-1:0] rsp_status;
   logic [CNT_W-1:0]  rsp_fill_count;
   logic              rsp_last;

   int error_count;
   int outstanding;

   // The stimulus keeps a rough idea of how full the buffer is so that it
   // can aim positions and run lengths at the filled region. It steers the
   // stimulus only; all checking is done by the checker.
   int fill_guess   = 0;
   int idle_pct     = 0;
   int beats_sent   = 0;
   int random_start = 0;
   bit random_phase = 1'b0;

   char_buffer_editor_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_byte_in   (req_byte_in),
      .req_position  (req_position),
      .req_run_length(req_run_length),
      .rsp_strobe    (rsp_strobe),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_status    (rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_last      (rsp_last)
   );

   edit_result_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_byte_in   (req_byte_in),
      .req_position  (req_position),
      .req_run_length(req_run_length),
      .rsp_strobe    (rsp_strobe),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_status    (rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_last      (rsp_last),
      .run_done      (run_done),
      .error_count   (error_count),
      .outstanding   (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Guard against a hung block. The slowest legal run is well under a tenth
   // of this: every command shifting or streaming the whole buffer, plus the
   // longest sender gaps.
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   // Presents one command beat and waits for the edge that accepts it. In the
   // idling phases the sender may first drop start for a random gap, with
   // junk on the fields, so that gaps land at every point of the block's work.
   // Start is left high on return; the next call either keeps it high for a
   // back-to-back beat or lowers it, so it is assigned only once per step.
   // During the random part the idling phase follows the number of beats
   // sent, so long fill episodes spread over the phases too.
   task automatic send_edit(input cmd_type op, input int b, input int pos, input int len);
      int gap;
      int done_now;
      if (random_phase) begin
         done_now = beats_sent - random_start;
         if (done_now < 21)      idle_pct = 0;
         else if (done_now < 42) idle_pct = 47;
         else if (done_now < 63) idle_pct = 21;
         else                    idle_pct = 0;
      end
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap            = $urandom_range(1, 10);
         start          <= 1'b0;
         req_cmd        <= CMD_W'($urandom_range(7));
         req_byte_in    <= BYTE_W'($urandom_range(255));
         req_position   <= POS_W'($urandom_range(63));
         req_run_length <= LEN_W'($urandom_range(64));
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= op;
      req_byte_in    <= BYTE_W'(b);
      req_position   <= POS_W'(pos);
      req_run_length <= LEN_W'(len);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      beats_sent++;
      case (op)
         CMD_APPEND: if (fill_guess < CAPACITY) fill_guess++;
         CMD_INSERT: if (pos < fill_guess && fill_guess < CAPACITY) fill_guess++;
         CMD_POP:    if (fill_guess > 0) fill_guess--;
         CMD_REMOVE: if (pos < fill_guess) fill_guess--;
         CMD_CLEAR:  fill_guess = 0;
         default:    ;
      endcase
   endtask

   // One random command. Most positions fall inside the filled region and
   // most runs stay within it; the rest are noise that should draw errors.
   task automatic random_edit();
      int      pick;
      int      pos;
      int      len;
      cmd_type op;
      pick = $urandom_range(99);
      if (fill_guess > 0 && $urandom_range(9) < 8) pos = $urandom_range(fill_guess - 1);
      else pos = $urandom_range(63);
      len = $urandom_range(64);
      if (pick < 30)      op = CMD_APPEND;
      else if (pick < 42) op = CMD_INSERT;
      else if (pick < 52) op = CMD_SET;
      else if (pick < 64) op = CMD_GET;
      else if (pick < 72) op = CMD_POP;
      else if (pick < 82) op = CMD_REMOVE;
      else if (pick < 84) op = CMD_CLEAR;
      else                op = CMD_RUN;
      if (op == CMD_RUN && pos < fill_guess && $urandom_range(9) < 7)
         len = $urandom_range(fill_guess - pos);
      send_edit(op, $urandom_range(255), pos, len);
   endtask

   // Appends until the buffer is full, then works the full buffer: growth
   // refused in both forms, a run across the whole capacity, access to the
   // top entry, and the longest shifts in each direction.
   task automatic fill_to_capacity();
      while (fill_guess < CAPACITY)
         send_edit(CMD_APPEND, $urandom_range(255), $urandom_range(63), $urandom_range(64));
      send_edit(CMD_APPEND, $urandom_range(255), 0, 0);
      send_edit(CMD_INSERT, $urandom_range(255), $urandom_range(63), 0);
      send_edit(CMD_RUN, 0, 0, CAPACITY);
      send_edit(CMD_GET, 0, CAPACITY - 1, 0);
      send_edit(CMD_SET, $urandom_range(255), CAPACITY - 1, 0);
      send_edit(CMD_RUN, 0, CAPACITY - 1, 1);
      send_edit(CMD_RUN, 0, 1, CAPACITY);
      send_edit(CMD_REMOVE, 0, 0, 0);
      send_edit(CMD_INSERT, $urandom_range(255), 0, 0);
   endtask

   initial begin
      int  done;
      int  guard;
      bit  filled;
      filled = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats, back to back. First pop and every indexed command on an
      // empty buffer: pop reports empty, everything indexed is out of bounds.
      send_edit(CMD_POP,    8'h11, 0, 0);
      send_edit(CMD_REMOVE, 8'h22, 0, 0);
      send_edit(CMD_GET,    8'h33, 0, 0);
      send_edit(CMD_SET,    8'h44, 0, 0);
      send_edit(CMD_INSERT, 8'h55, 0, 0);
      send_edit(CMD_RUN,    8'h66, 0, 0);
      // Build a short buffer, using the byte extremes.
      send_edit(CMD_APPEND, 8'h00, 63, 64);
      send_edit(CMD_APPEND, 8'hFF, 0, 0);
      send_edit(CMD_APPEND, 8'hA5, 0, 0);
      send_edit(CMD_INSERT, 8'h5A, 0, 0);
      send_edit(CMD_INSERT, 8'hC3, 2, 0);
      // Insert at the end position is an error rather than an append.
      send_edit(CMD_INSERT, 8'h99, 5, 0);
      send_edit(CMD_SET,    8'h3C, 4, 0);
      send_edit(CMD_SET,    8'hFF, 0, 0);
      send_edit(CMD_GET,    8'h00, 0, 0);
      send_edit(CMD_GET,    8'h00, 4, 0);
      send_edit(CMD_GET,    8'h00, 63, 0);
      // Runs: one ending exactly at the fill count, a zero-length one with a
      // valid start, one running past the end, and one starting at the end.
      send_edit(CMD_RUN,    8'h00, 1, 4);
      send_edit(CMD_RUN,    8'h00, 0, 0);
      send_edit(CMD_RUN,    8'h00, 2, 4);
      send_edit(CMD_RUN,    8'h00, 5, 0);
      send_edit(CMD_REMOVE, 8'h00, 0, 0);
      send_edit(CMD_REMOVE, 8'h00, 3, 0);
      send_edit(CMD_POP,    8'h00, 0, 0);
      send_edit(CMD_CLEAR,  8'h00, 0, 0);
      // Emptiness follows the count, whatever the stale entries hold.
      send_edit(CMD_POP,    8'h00, 0, 0);

      // Random beats in four phases of sender idling: none, heavy, light,
      // and none again. The first full-buffer episode is forced early.
      random_start = beats_sent;
      random_phase = 1'b1;
      done         = 0;
      while (done < RANDOM_BEATS) begin
         if ((!filled && done >= 10) || $urandom_range(24) == 0) begin
            filled = 1'b1;
            fill_to_capacity();
         end else begin
            random_edit();
         end
         done = beats_sent - random_start;
      end

      // Drain: wait for every expected beat, then give the block time to
      // show any stray beat before the checker looks for leftovers.
      start <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (outstanding != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
